### hw/rtl/tccw_pkg.sv
// Shared constants and control/status types for the text console cell writer.
`default_nettype none

package tccw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int CELL_W     = CHAR_W + COLOR_W;
    localparam int OP_W       = 2;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ADDR_EXT_W = COL_W + ROW_W;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - (CELL_W + COL_W + ROW_W);

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

    typedef struct packed {
        logic item_load;   // capture the accepted item
        logic exec;        // carry out the held operation
        logic sweep_run;   // write one fill cell and step the sweep counter
        logic sweep_init;  // fill with the reset colour rather than text_color
        logic out_load;    // load the result register
        logic out_held;    // result from held registers rather than next cursor
    } tccw_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            sweep_last;
    } tccw_stat_t;

endpackage

`default_nettype wire

### hw/rtl/tccw_ctrl.sv
// Controller state machine: sequencing of accept, execute, fill sweep and result.
`default_nettype none

module tccw_ctrl
    import tccw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire tccw_stat_t stat,
    output tccw_cmd_t       cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_init = 1'b1;
                if (stat.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (stat.opcode)
                    OP_CLEAR: state_next = ST_SWEEP;
                    OP_READ:  state_next = ST_HOLD;
                    default: begin
                        if (out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_HOLD;
                        end
                    end
                endcase
            end
            ST_SWEEP: begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_last) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_held = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)  m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted item not followed by execute");

    a_exec_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> (state_reg != ST_EXEC))
        else $error("execute lasted more than one cycle");

    a_idle_sweep_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !stat.sweep_last)
        else $error("sweep counter not back at zero when idle");

endmodule

`default_nettype wire

### hw/rtl/tccw_dp.sv
// Datapath: item registers, cursor, cell store, fill sweep counter and result register.
`default_nettype none

module tccw_dp
    import tccw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tccw_cmd_t            cmd,
    output tccw_stat_t                stat,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]      s_tuser,
    input  wire logic                 cfg_we,
    input  wire logic [COLOR_W-1:0]   cfg_wdata,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic [CELL_W-1:0] cell_mem [CELL_COUNT];

    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COL_W-1:0]   tgt_col_reg;
    logic [ROW_W-1:0]   tgt_row_reg;

    logic [COLOR_W-1:0] text_color_reg;
    logic [COL_W-1:0]   cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]   cursor_row_reg, cursor_row_next;
    logic [ADDR_W-1:0]  sweep_cnt_reg;

    logic [CELL_W-1:0]  rd_data_reg;
    logic               rd_ok_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;

    logic               is_nl, is_bs, col_last, row_last, in_range, item_wr, sweep_last;
    logic [ROW_W-1:0]   row_inc;
    logic [COL_W-1:0]   nxt_col, acc_col;
    logic [ROW_W-1:0]   nxt_row, acc_row;
    logic [CELL_W-1:0]  item_cell;
    logic [ADDR_EXT_W-1:0] acc_addr_full;
    logic [ADDR_W-1:0]  acc_addr, wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               wr_en;
    logic [COLOR_W-1:0] fill_color;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            op_reg      <= s_tuser;
            char_reg    <= s_tdata[CHAR_W-1:0];
            color_reg   <= s_tdata[CHAR_W +: COLOR_W];
            tgt_col_reg <= s_tdata[CELL_W +: COL_W];
            tgt_row_reg <= s_tdata[CELL_W+COL_W +: ROW_W];
        end
    end

    assign is_nl    = (char_reg == CH_NEWLINE);
    assign is_bs    = (char_reg == CH_BACKSPACE);
    assign col_last = (cursor_col_reg == COL_W'(SCREEN_COLUMNS - 1));
    assign row_last = (cursor_row_reg == ROW_W'(SCREEN_ROWS - 1));
    assign row_inc  = row_last ? '0 : cursor_row_reg + 1'b1;
    assign in_range = ({1'b0, tgt_col_reg} < (COL_W+1)'(SCREEN_COLUMNS))
                   && ({1'b0, tgt_row_reg} < (ROW_W+1)'(SCREEN_ROWS));

    // cursor after a put-character
    always_comb begin
        nxt_col = cursor_col_reg;
        nxt_row = cursor_row_reg;
        if (is_nl) begin
            nxt_col = '0;
            nxt_row = row_inc;
        end else if (is_bs) begin
            if (cursor_col_reg != '0) begin
                nxt_col = cursor_col_reg - 1'b1;
            end else if (cursor_row_reg != '0) begin
                nxt_row = cursor_row_reg - 1'b1;
                nxt_col = COL_W'(SCREEN_COLUMNS - 1);
            end
        end else if (col_last) begin
            nxt_col = '0;
            nxt_row = row_inc;
        end else begin
            nxt_col = cursor_col_reg + 1'b1;
        end
    end

    always_comb begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        case (op_reg)
            OP_PUT: begin
                cursor_col_next = nxt_col;
                cursor_row_next = nxt_row;
            end
            OP_CLEAR: begin
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            default: ;
        endcase
    end

    // cell position touched by the item; backspace writes after stepping back
    always_comb begin
        acc_col   = tgt_col_reg;
        acc_row   = tgt_row_reg;
        item_cell = {color_reg, char_reg};
        item_wr   = 1'b0;
        case (op_reg)
            OP_PUT: begin
                item_wr = !is_nl;
                if (is_bs) begin
                    acc_col   = nxt_col;
                    acc_row   = nxt_row;
                    item_cell = {text_color_reg, CH_SPACE};
                end else begin
                    acc_col   = cursor_col_reg;
                    acc_row   = cursor_row_reg;
                    item_cell = {text_color_reg, char_reg};
                end
            end
            OP_WRITE: item_wr = in_range;
            default: ;
        endcase
    end

    assign acc_addr_full = ADDR_EXT_W'(acc_row) * ADDR_EXT_W'(SCREEN_COLUMNS)
                         + ADDR_EXT_W'(acc_col);
    assign acc_addr      = acc_addr_full[ADDR_W-1:0];

    assign sweep_last = (sweep_cnt_reg == ADDR_W'(CELL_COUNT - 1));
    assign fill_color = cmd.sweep_init ? RESET_COLOR : text_color_reg;
    assign wr_en      = cmd.sweep_run || (cmd.exec && item_wr);
    assign wr_addr    = cmd.sweep_run ? sweep_cnt_reg : acc_addr;
    assign wr_data    = cmd.sweep_run ? {fill_color, CH_SPACE} : item_cell;

    always_ff @(posedge aclk) begin
        if (wr_en) cell_mem[wr_addr] <= wr_data;
        if (cmd.exec) rd_data_reg <= cell_mem[acc_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= RESET_COLOR;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            sweep_cnt_reg  <= '0;
            rd_ok_reg      <= 1'b0;
        end else begin
            if (cfg_we) text_color_reg <= cfg_wdata;
            if (cmd.exec) begin
                cursor_col_reg <= cursor_col_next;
                cursor_row_reg <= cursor_row_next;
                rd_ok_reg      <= (op_reg == OP_READ) && in_range;
            end
            if (cmd.sweep_run) sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_held) begin
                out_cell_reg <= rd_ok_reg ? rd_data_reg : '0;
                out_col_reg  <= cursor_col_reg;
                out_row_reg  <= cursor_row_reg;
            end else begin
                out_cell_reg <= '0;
                out_col_reg  <= cursor_col_next;
                out_row_reg  <= cursor_row_next;
            end
        end
    end

    assign m_tdata         = {{M_PAD_W{1'b0}}, out_row_reg, out_col_reg, out_cell_reg};
    assign stat.opcode     = op_reg;
    assign stat.sweep_last = sweep_last;

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cursor_col_reg} < (COL_W+1)'(SCREEN_COLUMNS))
        && ({1'b0, cursor_row_reg} < (ROW_W+1)'(SCREEN_ROWS)))
        else $error("cursor outside the screen");

    a_sweep_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.sweep_run && cmd.exec))
        else $error("fill sweep overlaps item execution");

    a_clear_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (op_reg == OP_CLEAR)) |=> (cursor_col_reg == '0 && cursor_row_reg == '0))
        else $error("clear did not home the cursor");

endmodule

`default_nettype wire

### hw/rtl/text_console_cell_writer_unit.sv
// Top level of the text console cell writer: controller plus datapath.
//
// Usage:
//   s_ channel carries one operation per item: s_tuser is the opcode (put
//   character, write at position, clear, read cell), s_tdata the operands.
//   m_ channel returns one result per item: the cell read (zero unless a read
//   at a valid position) and the cursor after the operation.
//   cfg_we/cfg_wdata set the attribute byte used by put-character and clear.
// Timing:
//   put-character and write-at-position go from accept to the execute state and
//   then to the result register; read also passes the hold state (the cell
//   store's read data is registered), and clear writes one cell per cycle through
//   all 2000 cells before the hold state. One item is worked on at a time; the
//   next is taken once the previous has reached the result register.
// Reset:
//   aresetn (synchronous, active low) homes the cursor, sets the attribute to
//   7 and starts a pass over all 2000 cells writing spaces in colour 7; s_tready stays
//   low until it ends. Configuration writes are taken during the pass.
// Stall:
//   a result waiting on m_tready holds in the result register; one further
//   item is accepted and executed, then waits until the register frees.
`default_nettype none

module text_console_cell_writer_unit
    import tccw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // char_code, cell_color, target_col, target_row
    input  wire logic [OP_W-1:0]      s_tuser,   // opcode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // read_cell, cursor_col_out, cursor_row_out
    input  wire logic                 cfg_we,
    input  wire logic [COLOR_W-1:0]   cfg_wdata
);

    tccw_cmd_t  cmd;
    tccw_stat_t stat;

    tccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tccw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
